FILE: sv/tmsp_pkg.sv
// shared types and constants of the trade message stream parser
package tmsp_pkg;

    typedef logic [7:0] t_byte;

    // message framing
    localparam t_byte       TRADE_TYPE  = 8'h50;
    localparam t_byte       SPACE_CHAR  = 8'h20;
    localparam int unsigned CELL_COUNT  = 43;
    localparam logic [5:0]  CAPTURE_LEN = 6'd44;

    // cell index of each field's first byte (cell k holds body byte k+1)
    localparam int unsigned CELL_LOCATE = 0;
    localparam int unsigned CELL_TRACK  = 2;
    localparam int unsigned CELL_TIME   = 4;
    localparam int unsigned CELL_ORDER  = 10;
    localparam int unsigned CELL_SIDE   = 18;
    localparam int unsigned CELL_SHARES = 19;
    localparam int unsigned CELL_SYMBOL = 23;
    localparam int unsigned CELL_PRICE  = 31;
    localparam int unsigned CELL_MATCH  = 35;
    localparam int unsigned SYMBOL_LEN  = 8;

    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } t_phase;

    // framer to top level
    typedef struct packed {
        logic clear;      // new message with a body starts
        logic step;       // body beat accepted
        logic first;      // this body beat is the message type
        logic last;       // this body beat ends the message
        logic trade;      // message type is a trade
        logic short_msg;  // message ends before the last captured byte
    } t_frame_ctl;

    // top level to each cell
    typedef struct packed {
        logic clear;
        logic step;
    } t_cell_ctl;

endpackage

FILE: sv/tmsp_frame.sv
// framing state machine: length prefix, remaining count and body offset
module tmsp_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_beat,
    input  tmsp_pkg::t_byte     i_byte,
    output tmsp_pkg::t_frame_ctl o_ctl,
    output logic                o_last_pending
);
    import tmsp_pkg::*;

    t_phase      r_phase, n_phase;
    t_byte       r_len_hi, n_len_hi;
    logic [15:0] r_left, n_left;
    logic [5:0]  r_offset, n_offset;
    t_byte       r_kind, n_kind;
    t_byte       w_kind;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN_HI;
            r_len_hi <= '0;
            r_left   <= '0;
            r_offset <= '0;
            r_kind   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len_hi <= n_len_hi;
            r_left   <= n_left;
            r_offset <= n_offset;
            r_kind   <= n_kind;
        end
    end

    // message type as it stands after this beat
    assign w_kind = (r_offset == '0) ? i_byte : r_kind;

    // next state and control
    always_comb begin
        n_phase  = r_phase;
        n_len_hi = r_len_hi;
        n_left   = r_left;
        n_offset = r_offset;
        n_kind   = r_kind;
        o_ctl    = '0;
        case (r_phase)
            PH_LEN_HI: begin
                if (i_beat) begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                if (i_beat) begin
                    if ({r_len_hi, i_byte} == 16'd0) begin
                        n_phase = PH_LEN_HI;
                    end else begin
                        n_left    = {r_len_hi, i_byte};
                        n_offset  = '0;
                        n_kind    = '0;
                        n_phase   = PH_BODY;
                        o_ctl.clear = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (i_beat) begin
                    o_ctl.step  = 1'b1;
                    o_ctl.first = (r_offset == '0);
                    n_kind      = w_kind;
                    if (r_offset < CAPTURE_LEN) begin
                        n_offset = r_offset + 6'd1;
                    end
                    n_left = r_left - 16'd1;
                    if (r_left == 16'd1) begin
                        o_ctl.last      = 1'b1;
                        o_ctl.trade     = (w_kind == TRADE_TYPE);
                        o_ctl.short_msg = (n_offset < CAPTURE_LEN);
                        n_phase         = PH_LEN_HI;
                    end
                end
            end
            default: begin
                n_phase = PH_LEN_HI;
            end
        endcase
    end

    // next body beat closes the message
    assign o_last_pending = (r_phase == PH_BODY) && (r_left == 16'd1);

endmodule

FILE: sv/tmsp_cell.sv
// one byte cell of the capture chain with write token and symbol end flag
module tmsp_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmsp_pkg::t_cell_ctl i_ctl,
    input  tmsp_pkg::t_byte    i_byte,
    input  logic               i_is_symbol,
    input  logic               i_token,
    input  logic               i_ended,
    output logic               o_token,
    output logic               o_ended,
    output tmsp_pkg::t_byte    o_byte_next
);
    import tmsp_pkg::*;

    logic  r_token, n_token;
    logic  r_ended, n_ended;
    t_byte r_byte, n_byte;
    logic  w_write;
    logic  w_cut;

    // this cell takes the beat when it holds the token
    assign w_write = i_ctl.step && r_token;
    assign w_cut   = i_is_symbol && (i_ended || (i_byte == SPACE_CHAR));

    always_comb begin
        n_token = r_token;
        n_ended = r_ended;
        n_byte  = r_byte;
        if (i_ctl.clear) begin
            n_token = 1'b0;
            n_ended = 1'b0;
            n_byte  = '0;
        end else if (i_ctl.step) begin
            n_token = i_token;
            if (w_write) begin
                n_byte  = w_cut ? '0 : i_byte;
                n_ended = w_cut;
            end
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_token <= n_token;
            r_ended <= n_ended;
        end
    end

    // captured byte
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_token     = r_token;
    assign o_ended     = r_ended;
    assign o_byte_next = n_byte;

endmodule

FILE: sv/trade_message_stream_parser.sv
// top level of the trade message stream parser: framer, cell chain, record register
// The parser takes one stream byte per cycle, sustained. A byte is held off only when
// it is the last body byte of a message and the previous record still waits in the
// output register with i_out_ready low; every other byte is taken while a record waits.
// Each message is a two-byte big-endian length and a body. Body bytes 1 to 43 land in a
// row of 43 byte cells, a write token moving one cell per body beat; the record appears
// on the output in the cycle after the last body byte of a 'P' message while
// i_cfg_data last written is 1 (reset value 1). Zero-length messages are skipped.
module trade_message_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_locate_code,
    output logic [15:0] o_track_num,
    output logic [47:0] o_event_time,
    output logic [63:0] o_order_reference,
    output logic [7:0]  o_side_code,
    output logic [31:0] o_share_count,
    output logic [63:0] o_symbol_chars,
    output logic [31:0] o_trade_price,
    output logic [63:0] o_match_id,
    output logic        o_short_message,
    output logic [31:0] o_trades_seen
);
    import tmsp_pkg::*;

    logic        r_enable;
    logic [31:0] r_total;
    logic        r_out_valid;
    logic        w_beat;
    logic        w_last_pending;
    logic        w_emit;
    t_frame_ctl  w_fctl;
    t_cell_ctl   w_cctl;
    logic [CELL_COUNT-1:0] w_token;
    logic [CELL_COUNT-1:0] w_ended;
    t_byte       w_next [CELL_COUNT];

    // input handshake
    assign o_in_ready = !(r_out_valid && !i_out_ready && w_last_pending);
    assign w_beat     = i_in_valid && o_in_ready;

    // framing
    tmsp_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (w_beat),
        .i_byte         (i_data_byte),
        .o_ctl          (w_fctl),
        .o_last_pending (w_last_pending)
    );

    assign w_cctl.clear = w_fctl.clear;
    assign w_cctl.step  = w_fctl.step;

    // capture chain
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        logic w_tok_in;
        logic w_end_in;
        if (k == 0) begin : g_head
            assign w_tok_in = w_fctl.first;
            assign w_end_in = 1'b0;
        end else begin : g_link
            assign w_tok_in = w_token[k-1];
            assign w_end_in = w_ended[k-1];
        end
        tmsp_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_cctl),
            .i_byte      (i_data_byte),
            .i_is_symbol ((k >= CELL_SYMBOL) && (k < CELL_SYMBOL + SYMBOL_LEN)),
            .i_token     (w_tok_in),
            .i_ended     (w_end_in),
            .o_token     (w_token[k]),
            .o_ended     (w_ended[k]),
            .o_byte_next (w_next[k])
        );
    end

    // enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    assign w_emit = w_fctl.last && w_fctl.trade && r_enable;

    // record valid and trade counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_out_valid <= w_emit || (r_out_valid && !i_out_ready);
            if (w_emit) begin
                r_total <= r_total + 32'd1;
            end
        end
    end

    // record payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_locate_code     <= {w_next[CELL_LOCATE], w_next[CELL_LOCATE+1]};
            o_track_num       <= {w_next[CELL_TRACK], w_next[CELL_TRACK+1]};
            o_event_time      <= {w_next[CELL_TIME],   w_next[CELL_TIME+1],
                                  w_next[CELL_TIME+2], w_next[CELL_TIME+3],
                                  w_next[CELL_TIME+4], w_next[CELL_TIME+5]};
            o_order_reference <= {w_next[CELL_ORDER],   w_next[CELL_ORDER+1],
                                  w_next[CELL_ORDER+2], w_next[CELL_ORDER+3],
                                  w_next[CELL_ORDER+4], w_next[CELL_ORDER+5],
                                  w_next[CELL_ORDER+6], w_next[CELL_ORDER+7]};
            o_side_code       <= w_next[CELL_SIDE];
            o_share_count     <= {w_next[CELL_SHARES],   w_next[CELL_SHARES+1],
                                  w_next[CELL_SHARES+2], w_next[CELL_SHARES+3]};
            o_symbol_chars    <= {w_next[CELL_SYMBOL],   w_next[CELL_SYMBOL+1],
                                  w_next[CELL_SYMBOL+2], w_next[CELL_SYMBOL+3],
                                  w_next[CELL_SYMBOL+4], w_next[CELL_SYMBOL+5],
                                  w_next[CELL_SYMBOL+6], w_next[CELL_SYMBOL+7]};
            o_trade_price     <= {w_next[CELL_PRICE],   w_next[CELL_PRICE+1],
                                  w_next[CELL_PRICE+2], w_next[CELL_PRICE+3]};
            o_match_id        <= {w_next[CELL_MATCH],   w_next[CELL_MATCH+1],
                                  w_next[CELL_MATCH+2], w_next[CELL_MATCH+3],
                                  w_next[CELL_MATCH+4], w_next[CELL_MATCH+5],
                                  w_next[CELL_MATCH+6], w_next[CELL_MATCH+7]};
            o_short_message   <= w_fctl.short_msg;
            o_trades_seen     <= r_total + 32'd1;
        end
    end

    assign o_out_valid = r_out_valid;

    // a new record never lands on one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || i_out_ready))
        else $error("record overwrote a waiting record");

    // at most one cell holds the write token
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_token))
        else $error("more than one write token in the cell chain");

    // each record carries the count just advanced
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (o_trades_seen == r_total) && o_out_valid)
        else $error("trade count out of step with records");

endmodule
